// File: rtl/core/segalloc_pkg.sv
// ----------------------------------------------------------------------------
// segalloc_pkg
// Shared types, widths and helpers of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package segalloc_pkg;

	localparam int DATA_UNITS = 1024;
	localparam int IDX_W = $clog2(DATA_UNITS);
	localparam int CNT_W = $clog2(DATA_UNITS + 1);
	localparam int REQ_W = 11;
	localparam int POS_W = 10;
	localparam int CMP_W = (CNT_W > REQ_W) ? CNT_W : REQ_W;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_COMMIT = 2'd1,
		OP_FREE   = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ASCAN,
		S_LOCATE,
		S_UP,
		S_WIN,
		S_FCALC,
		S_DOWN,
		S_REPORT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             head;
		logic [CNT_W-1:0] len;
		logic [CNT_W-1:0] size;
	} entry_t;

	function automatic logic [CMP_W-1:0] ext_cnt(input logic [CNT_W-1:0] v);
		return CMP_W'(v);
	endfunction

	function automatic logic [CMP_W-1:0] ext_req(input logic [REQ_W-1:0] v);
		return CMP_W'(v);
	endfunction

	function automatic logic [CMP_W-1:0] ext_pos(input logic [POS_W-1:0] v);
		return CMP_W'(v);
	endfunction

	function automatic logic [POS_W-1:0] to_pos(input logic [CMP_W-1:0] v);
		return v[POS_W-1:0];
	endfunction

	function automatic logic [REQ_W-1:0] to_len(input logic [CMP_W-1:0] v);
		return v[REQ_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] to_cnt(input logic [CMP_W-1:0] v);
		return v[CNT_W-1:0];
	endfunction

endpackage

// File: rtl/core/segalloc_if.sv
// ----------------------------------------------------------------------------
// segalloc_if
// Request and response channels of the segment allocator.
// ----------------------------------------------------------------------------
interface segalloc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [10:0] req_length;
	logic [9:0] chunk_number;
	logic [9:0] node_number;

	modport source (output valid, output opcode, output req_length,
		output chunk_number, output node_number, input ready);
	modport sink (input valid, input opcode, input req_length,
		input chunk_number, input node_number, output ready);
endinterface

interface segalloc_rsp_if;
	logic        valid;
	logic        ready;
	logic        failed;
	logic [9:0]  out_chunk;
	logic [9:0]  out_node;
	logic [9:0]  base_address;
	logic [10:0] used_length;
	logic [10:0] segment_size;

	modport source (output valid, output failed, output out_chunk, output out_node,
		output base_address, output used_length, output segment_size, input ready);
	modport sink (input valid, input failed, input out_chunk, input out_node,
		input base_address, input used_length, input segment_size, output ready);
endinterface

// File: rtl/core/segment_allocator_first_fit.sv
// ----------------------------------------------------------------------------
// segment_allocator_first_fit
// First-fit segment allocator with coalescing; the segment table lives in
// one synchronous memory that a sequencer scans, shifts and rewrites.
// ----------------------------------------------------------------------------
//  channel   role    beat
//  req_ch    sink    opcode, req_length, chunk_number, node_number
//  rsp_ch    source  failed, out_chunk, out_node, base_address,
//                    used_length, segment_size
//
//  one request at a time; one table entry a cycle
//  alloc: first-fit scan, shift for a split, then a report scan up to the
//  segment; commit, query: locate + report
//  free: locate, six-entry window read, shift down for merges
//  reset clears the state, the counts and the valid flags; the table is never cleared
//  a finished response waits in the output register; the next request is
//  taken meanwhile and stalls only when its own response is ready
// ----------------------------------------------------------------------------
module segment_allocator_first_fit (
	input  logic                  clk,
	input  logic                  arst_n,
	segalloc_req_if.sink          req_ch,
	segalloc_rsp_if.source        rsp_ch
);

	localparam int CW = segalloc_pkg::CNT_W;
	localparam int IW = segalloc_pkg::IDX_W;

	segalloc_pkg::entry_t mem [segalloc_pkg::DATA_UNITS];

	segalloc_pkg::state_t state_q, state_d;
	segalloc_pkg::op_t    op_q, op_d;
	logic [10:0] req_q, req_d;
	logic [9:0]  cn_q, cn_d, nn_q, nn_d;
	logic [CW-1:0] cnt_q, cnt_d, chk_q, chk_d;
	logic [CW-1:0] rk_q, rk_d, acc_q, acc_d, hd_q, hd_d, lh_q, lh_d;
	logic [CW-1:0] tgt_q, tgt_d, d_q, d_d;
	segalloc_pkg::entry_t ent_q, ent_d;
	segalloc_pkg::entry_t win_q [6];
	segalloc_pkg::entry_t win_d [6];
	logic [5:0] wv_q, wv_d;
	logic [2:0] wc_q, wc_d;

	logic v_s1, v_d;
	logic [CW-1:0] ix_s1, ix_d;
	logic [2:0] sl_s1, sl_d;
	segalloc_pkg::entry_t rd_s1;

	logic re, we;
	logic [CW-1:0] ra, wa;
	segalloc_pkg::entry_t wd;

	logic rs_fail_q, rs_fail_d;
	logic [9:0] rs_chunk_q, rs_chunk_d, rs_node_q, rs_node_d, rs_base_q, rs_base_d;
	logic [10:0] rs_len_q, rs_len_d, rs_size_q, rs_size_d;
	logic ov_q, ov_d;
	logic o_fail_q;
	logic [9:0] o_chunk_q, o_node_q, o_base_q;
	logic [10:0] o_len_q, o_size_q;

	logic [CW-1:0] hd_n, lh_n, space, pw;
	logic hit, fail_now, rpt_now, free_now, load;
	logic r3, l1, single, mn, mp;
	logic [2:0] lsl, rsl, lslf, rslf;
	logic [CW-1:0] sum, absa, dc;

	// table memory
	always_ff @(posedge clk) begin
		if (we)
			mem[wa[IW-1:0]] <= wd;
		if (re)
			rd_s1 <= mem[ra[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= segalloc_pkg::S_IDLE;
			cnt_q   <= '0;
			chk_q   <= '0;
			v_s1    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			chk_q   <= chk_d;
			v_s1    <= v_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		req_q <= req_d;
		cn_q  <= cn_d;
		nn_q  <= nn_d;
		rk_q  <= rk_d;
		acc_q <= acc_d;
		hd_q  <= hd_d;
		lh_q  <= lh_d;
		tgt_q <= tgt_d;
		d_q   <= d_d;
		ent_q <= ent_d;
		win_q <= win_d;
		wv_q  <= wv_d;
		wc_q  <= wc_d;
		ix_s1 <= ix_d;
		sl_s1 <= sl_d;
		rs_fail_q  <= rs_fail_d;
		rs_chunk_q <= rs_chunk_d;
		rs_node_q  <= rs_node_d;
		rs_base_q  <= rs_base_d;
		rs_len_q   <= rs_len_d;
		rs_size_q  <= rs_size_d;
		if (load) begin
			o_fail_q  <= rs_fail_q;
			o_chunk_q <= rs_chunk_q;
			o_node_q  <= rs_node_q;
			o_base_q  <= rs_base_q;
			o_len_q   <= rs_len_q;
			o_size_q  <= rs_size_q;
		end
	end

	// merge window of a free: slots hold entries tgt-2 .. tgt+3
	always_comb begin
		r3 = wv_q[3] && !win_q[3].head && (win_q[3].len == '0);
		l1 = !win_q[2].head && wv_q[1] && (win_q[1].len == '0);
		rsl = r3 ? 3'd3 : 3'd2;
		lsl = l1 ? 3'd1 : 3'd2;
		single = (l1 ? win_q[1].head : win_q[2].head) &&
			(r3 ? (!wv_q[4] || win_q[4].head) : (!wv_q[3] || win_q[3].head));
		if (r3)
			mn = single && wv_q[4] && (win_q[4].len == '0) &&
				(!wv_q[5] || win_q[5].head);
		else
			mn = single && wv_q[3] && (win_q[3].len == '0) &&
				(!wv_q[4] || win_q[4].head);
		if (l1)
			mp = single && wv_q[0] && (win_q[0].len == '0) &&
				((tgt_q == CW'(2)) || win_q[0].head);
		else
			mp = single && wv_q[1] && (win_q[1].len == '0) &&
				((tgt_q == CW'(1)) || win_q[1].head);
		lslf = lsl - {2'b00, mp};
		rslf = rsl + {2'b00, mn};
		sum = '0;
		for (int s = 0; s < 6; s++) begin
			if ((3'(s) >= lslf) && (3'(s) <= rslf))
				sum = sum + win_q[s].size;
		end
		absa = tgt_q + CW'(lslf) - CW'(2);
		dc = CW'(mn) + CW'(mp);
	end

	always_comb begin
		state_d = state_q;
		op_d = op_q; req_d = req_q; cn_d = cn_q; nn_d = nn_q;
		cnt_d = cnt_q; chk_d = chk_q;
		rk_d = rk_q; acc_d = acc_q; hd_d = hd_q; lh_d = lh_q;
		tgt_d = tgt_q; d_d = d_q; ent_d = ent_q;
		win_d = win_q; wv_d = wv_q; wc_d = wc_q;
		v_d = 1'b0; ix_d = ix_s1; sl_d = sl_s1;
		re = 1'b0; ra = '0; we = 1'b0; wa = '0; wd = '0;
		rs_fail_d = rs_fail_q; rs_chunk_d = rs_chunk_q; rs_node_d = rs_node_q;
		rs_base_d = rs_base_q; rs_len_d = rs_len_q; rs_size_d = rs_size_q;
		ov_d = ov_q && !rsp_ch.ready;
		load = 1'b0;
		fail_now = 1'b0; rpt_now = 1'b0; free_now = 1'b0; hit = 1'b0;
		hd_n = hd_q + CW'(rd_s1.head);
		lh_n = rd_s1.head ? ix_s1 : lh_q;
		space = rd_s1.size - rd_s1.len;
		pw = tgt_q + CW'(wc_q);

		case (state_q)
			segalloc_pkg::S_IDLE: begin
				if (req_ch.valid) begin
					op_d  = segalloc_pkg::op_t'(req_ch.opcode);
					req_d = req_ch.req_length;
					cn_d  = req_ch.chunk_number;
					nn_d  = req_ch.node_number;
					rk_d = '0; acc_d = '0; hd_d = '0; lh_d = '0;
					if (segalloc_pkg::op_t'(req_ch.opcode) == segalloc_pkg::OP_ALLOC) begin
						if (req_ch.req_length == '0)
							fail_now = 1'b1;
						else
							state_d = segalloc_pkg::S_ASCAN;
					end else begin
						state_d = segalloc_pkg::S_LOCATE;
					end
				end
			end
			segalloc_pkg::S_ASCAN: begin
				if (v_s1) begin
					acc_d = acc_q + rd_s1.size;
					hit = segalloc_pkg::ext_cnt(space) >= segalloc_pkg::ext_req(req_q);
				end
				if (hit) begin
					tgt_d = ix_s1;
					ent_d = rd_s1;
					if (rd_s1.len != '0) begin
						// shrink to the used part, tail goes in after shifting
						we = 1'b1; wa = ix_s1;
						wd = '{head: rd_s1.head, len: rd_s1.len, size: rd_s1.len};
						rk_d = cnt_q - 1'b1;
						state_d = segalloc_pkg::S_UP;
					end else begin
						rpt_now = 1'b1;
					end
				end else if (rk_q < cnt_q) begin
					re = 1'b1; ra = rk_q; v_d = 1'b1; ix_d = rk_q; rk_d = rk_q + 1'b1;
				end else if (!v_s1) begin
					if ((segalloc_pkg::ext_req(req_q) >
						segalloc_pkg::CMP_W'(segalloc_pkg::DATA_UNITS) -
						segalloc_pkg::ext_cnt(acc_q)) ||
						(segalloc_pkg::ext_cnt(cnt_q) >=
						segalloc_pkg::CMP_W'(segalloc_pkg::DATA_UNITS))) begin
						fail_now = 1'b1;
					end else begin
						// new chunk at the end
						we = 1'b1; wa = cnt_q;
						wd = '{head: 1'b1, len: '0,
							size: segalloc_pkg::to_cnt(segalloc_pkg::ext_req(req_q))};
						cnt_d = cnt_q + 1'b1;
						chk_d = chk_q + 1'b1;
						tgt_d = cnt_q;
						rpt_now = 1'b1;
					end
				end
			end
			segalloc_pkg::S_LOCATE: begin
				if (v_s1) begin
					hd_d = hd_n;
					lh_d = lh_n;
					hit = (hd_n != '0) &&
						(segalloc_pkg::ext_cnt(hd_n - 1'b1) == segalloc_pkg::ext_pos(cn_q)) &&
						(segalloc_pkg::ext_cnt(ix_s1 - lh_n) == segalloc_pkg::ext_pos(nn_q)) &&
						(segalloc_pkg::ext_pos(cn_q) < segalloc_pkg::ext_cnt(chk_q));
				end
				if (hit) begin
					tgt_d = ix_s1;
					ent_d = rd_s1;
					case (op_q)
						segalloc_pkg::OP_COMMIT: begin
							if (segalloc_pkg::ext_req(req_q) > segalloc_pkg::ext_cnt(rd_s1.size)) begin
								fail_now = 1'b1;
							end else begin
								we = 1'b1; wa = ix_s1;
								wd = '{head: rd_s1.head,
									len: segalloc_pkg::to_cnt(segalloc_pkg::ext_req(req_q)),
									size: rd_s1.size};
								rpt_now = 1'b1;
							end
						end
						segalloc_pkg::OP_QUERY: rpt_now = 1'b1;
						segalloc_pkg::OP_FREE: begin
							wc_d = '0;
							state_d = segalloc_pkg::S_WIN;
						end
						default: fail_now = 1'b1;
					endcase
				end else if (rk_q < cnt_q) begin
					re = 1'b1; ra = rk_q; v_d = 1'b1; ix_d = rk_q; rk_d = rk_q + 1'b1;
				end else if (!v_s1) begin
					fail_now = 1'b1;
				end
			end
			segalloc_pkg::S_UP: begin
				if (v_s1) begin
					we = 1'b1; wa = ix_s1 + 1'b1; wd = rd_s1;
				end
				if (rk_q > tgt_q) begin
					re = 1'b1; ra = rk_q; v_d = 1'b1; ix_d = rk_q; rk_d = rk_q - 1'b1;
				end else if (!v_s1) begin
					we = 1'b1; wa = tgt_q + 1'b1;
					wd = '{head: 1'b0, len: '0, size: ent_q.size - ent_q.len};
					cnt_d = cnt_q + 1'b1;
					tgt_d = tgt_q + 1'b1;
					rpt_now = 1'b1;
				end
			end
			segalloc_pkg::S_WIN: begin
				if (v_s1)
					win_d[sl_s1] = rd_s1;
				if (wc_q < 3'd6) begin
					wv_d[wc_q] = (pw >= CW'(2)) && ((pw - CW'(2)) < cnt_q);
					if ((pw >= CW'(2)) && ((pw - CW'(2)) < cnt_q)) begin
						re = 1'b1; ra = pw - CW'(2); v_d = 1'b1; sl_d = wc_q;
					end
					wc_d = wc_q + 1'b1;
				end else if (!v_s1) begin
					state_d = segalloc_pkg::S_FCALC;
				end
			end
			segalloc_pkg::S_FCALC: begin
				we = 1'b1; wa = absa;
				wd = '{head: (lslf == 3'd0) ? win_q[0].head :
					(lslf == 3'd1) ? win_q[1].head : win_q[2].head,
					len: '0, size: sum};
				chk_d = chk_q - dc;
				d_d = CW'(rslf - lslf);
				if (rslf == lslf) begin
					free_now = 1'b1;
				end else begin
					rk_d = absa + CW'(rslf - lslf) + 1'b1;
					state_d = segalloc_pkg::S_DOWN;
				end
			end
			segalloc_pkg::S_DOWN: begin
				if (v_s1) begin
					we = 1'b1; wa = ix_s1 - d_q; wd = rd_s1;
				end
				if (rk_q < cnt_q) begin
					re = 1'b1; ra = rk_q; v_d = 1'b1; ix_d = rk_q; rk_d = rk_q + 1'b1;
				end else if (!v_s1) begin
					cnt_d = cnt_q - d_q;
					free_now = 1'b1;
				end
			end
			segalloc_pkg::S_REPORT: begin
				if (v_s1) begin
					hd_d = hd_n;
					lh_d = lh_n;
					if (ix_s1 == tgt_q) begin
						hit = 1'b1;
						rs_fail_d  = 1'b0;
						rs_chunk_d = segalloc_pkg::to_pos(segalloc_pkg::ext_cnt(
							(hd_n != '0) ? hd_n - 1'b1 : '0));
						rs_node_d  = segalloc_pkg::to_pos(segalloc_pkg::ext_cnt(ix_s1 - lh_n));
						rs_base_d  = segalloc_pkg::to_pos(segalloc_pkg::ext_cnt(acc_q));
						rs_len_d   = segalloc_pkg::to_len(segalloc_pkg::ext_cnt(rd_s1.len));
						rs_size_d  = segalloc_pkg::to_len(segalloc_pkg::ext_cnt(rd_s1.size));
						state_d = segalloc_pkg::S_DONE;
					end else begin
						acc_d = acc_q + rd_s1.size;
					end
				end
				if (!hit && (rk_q <= tgt_q)) begin
					re = 1'b1; ra = rk_q; v_d = 1'b1; ix_d = rk_q; rk_d = rk_q + 1'b1;
				end
			end
			segalloc_pkg::S_DONE: begin
				if (!ov_q || rsp_ch.ready) begin
					load = 1'b1;
					ov_d = 1'b1;
					state_d = segalloc_pkg::S_IDLE;
				end
			end
			default: state_d = segalloc_pkg::S_IDLE;
		endcase

		if (fail_now) begin
			rs_fail_d = 1'b1; rs_chunk_d = '0; rs_node_d = '0;
			rs_base_d = '0; rs_len_d = '0; rs_size_d = '0;
			state_d = segalloc_pkg::S_DONE;
		end
		if (free_now) begin
			rs_fail_d = 1'b0; rs_chunk_d = cn_q; rs_node_d = nn_q;
			rs_base_d = '0; rs_len_d = '0; rs_size_d = '0;
			state_d = segalloc_pkg::S_DONE;
		end
		if (rpt_now) begin
			rk_d = '0; acc_d = '0; hd_d = '0; lh_d = '0;
			state_d = segalloc_pkg::S_REPORT;
		end
	end

	assign req_ch.ready        = (state_q == segalloc_pkg::S_IDLE);
	assign rsp_ch.valid        = ov_q;
	assign rsp_ch.failed       = o_fail_q;
	assign rsp_ch.out_chunk    = o_chunk_q;
	assign rsp_ch.out_node     = o_node_q;
	assign rsp_ch.base_address = o_base_q;
	assign rsp_ch.used_length  = o_len_q;
	assign rsp_ch.segment_size = o_size_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(segalloc_pkg::DATA_UNITS))
		else $error("segment count beyond table depth");

	a_chunks_le_segs: assert property (@(posedge clk) disable iff (!arst_n)
		chk_q <= cnt_q)
		else $error("more chunks than segments");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> (wa != ra))
		else $error("read and write of the same entry in one cycle");

	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == segalloc_pkg::S_IDLE) |-> !v_s1)
		else $error("table read in flight while idle");
`endif

endmodule
